/* rtl/gcc_pkg.sv */
// gcc_pkg: shared types and constants for the graph connectivity checker
// holds the input and result word structs, the row write and walk status structs
// no dependencies
package gcc_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int ROW_W            = 32;
  localparam int IDX_W            = 5;
  localparam int CNT_W            = 6;
  localparam int CFG_W            = 6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
  } in_word_t;

  typedef struct packed {
    logic             connected;
    logic [CNT_W-1:0] reached_count;
  } out_word_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] bits;
  } row_wr_t;

  typedef struct packed {
    logic      busy;
    logic      push;
    out_word_t res;
  } walk_st_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } walk_state_t;

endpackage

/* rtl/gcc_row_mem.sv */
// gcc_row_mem: adjacency row storage, one write port and one registered read port
// depends on gcc_pkg
module gcc_row_mem #(
  parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  logic                     clk,
  input  gcc_pkg::row_wr_t         wr,
  input  logic [AW-1:0]            rd_addr,
  output logic [gcc_pkg::ROW_W-1:0] rd_data
);
  import gcc_pkg::*;

  logic [ROW_W-1:0] mem [MAX_VERTICES];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[AW'(wr.idx)] <= wr.bits;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/gcc_walk.sv */
// gcc_walk: sequencer and merge unit that grows the reached set one row per cycle
// passes repeat until a full pass adds nothing; depends on gcc_pkg
module gcc_walk #(
  parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF,
  localparam int AW = $clog2(MAX_VERTICES),
  localparam int NW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NW-1:0]             n_eff,
  input  logic                      push_ok,
  input  logic [gcc_pkg::ROW_W-1:0] rd_data,
  output logic [AW-1:0]             rd_addr,
  output gcc_pkg::walk_st_t         st
);
  import gcc_pkg::*;

  localparam int VW = MAX_VERTICES;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  walk_state_t     state_r, state_nxt;
  logic [VW-1:0]   reached_r, reached_nxt;
  logic [VW-1:0]   mask_r, mask_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            changed_r, changed_nxt;
  logic [AW-1:0]   v_r, v_nxt;
  logic [AW-1:0]   v_q_r, v_q_nxt;
  logic            q_vld_r, q_vld_nxt;
  logic [AW-1:0]   n_m1_r, n_m1_nxt;

  logic            hit;
  logic            last;
  logic            chg;
  logic            push;
  logic [VW-1:0]   grow;
  logic [CW-1:0]   cnt_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      q_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      q_vld_r <= q_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reached_r <= reached_nxt;
    mask_r    <= mask_nxt;
    count_r   <= count_nxt;
    changed_r <= changed_nxt;
    v_r       <= v_nxt;
    v_q_r     <= v_q_nxt;
    n_m1_r    <= n_m1_nxt;
  end

  always_comb begin
    hit     = reached_r[v_q_r];
    grow    = reached_r | (VW'(rd_data) & mask_r & {VW{hit}});
    chg     = (grow != reached_r);
    last    = (v_q_r == n_m1_r);
    cnt_sum = count_r + CW'(hit);
  end

  always_comb begin
    state_nxt   = state_r;
    reached_nxt = reached_r;
    mask_nxt    = mask_r;
    count_nxt   = count_r;
    changed_nxt = changed_r;
    v_nxt       = v_r;
    v_q_nxt     = v_r;
    q_vld_nxt   = 1'b0;
    n_m1_nxt    = n_m1_r;
    push        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt   = ST_RUN;
          reached_nxt = VW'(1);
          count_nxt   = '0;
          changed_nxt = 1'b0;
          v_nxt       = '0;
          n_m1_nxt    = AW'(n_eff - NW'(1));
          for (int i = 0; i < VW; i++) begin
            mask_nxt[i] = (n_eff > NW'(i));
          end
        end
      end
      ST_RUN: begin
        v_nxt     = (v_r == n_m1_r) ? '0 : v_r + AW'(1);
        q_vld_nxt = 1'b1;
        if (q_vld_r) begin
          reached_nxt = grow;
          if (last) begin
            if (changed_r || chg) begin
              count_nxt   = '0;
              changed_nxt = 1'b0;
            end else begin
              count_nxt = cnt_sum;
              state_nxt = ST_HOLD;
              q_vld_nxt = 1'b0;
            end
          end else begin
            count_nxt   = cnt_sum;
            changed_nxt = changed_r || chg;
          end
        end
      end
      ST_HOLD: begin
        if (push_ok) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_addr               = v_r;
  assign st.push               = push;
  assign st.busy               = (state_r != ST_IDLE);
  assign st.res.connected      = (reached_r == mask_r);
  assign st.res.reached_count  = CNT_W'(count_r);

endmodule

/* rtl/graph_connectivity_check.sv */
// graph_connectivity_check: top level, config register, input decode and result register
// a load word stores one row; a check runs the merge loop over the single-port row read,
// one row per cycle, with passes repeated until stable
// no new word is taken while a check runs; the result register frees the walk unit
// reset clears control state and sets vertex_count to 1; stored rows are undefined until loaded
module graph_connectivity_check #(
  parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  gcc_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output gcc_pkg::out_word_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gcc_pkg::CFG_W-1:0] cfg_data
);
  import gcc_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  logic [CFG_W-1:0] vcount_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic             in_acc;
  logic             start;
  logic [NW-1:0]    n_eff;
  logic             push_ok;
  row_wr_t          wr;
  logic [AW-1:0]    rd_addr;
  logic [ROW_W-1:0] rd_data;
  walk_st_t         st;

  assign cfg_ready = 1'b1;
  assign in_stall  = st.busy;
  assign in_acc    = in_valid && !in_stall;
  assign start     = in_acc && (in_data.operation == OP_CHECK);
  assign push_ok   = !out_valid_r || !out_stall;

  always_comb begin
    wr.en   = in_acc && (in_data.operation == OP_LOAD) &&
              (32'(in_data.row_index) < MAX_VERTICES);
    wr.idx  = in_data.row_index;
    wr.bits = in_data.row_bits;
  end

  always_comb begin
    priority if (vcount_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(vcount_r) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vcount_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      vcount_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st.push) begin
      out_data_r <= st.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gcc_row_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_row_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gcc_walk #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .n_eff   (n_eff),
    .push_ok (push_ok),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .st      (st)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("check start did not make the block busy");

  a_push_only_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    st.push |-> push_ok)
    else $error("result pushed while output register is blocked");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.reached_count != '0))
    else $error("result reports zero vertices reached");

  a_rise_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st.push))
    else $error("output valid rose without a push from the walk unit");

endmodule
